/* sv/wrcd_pkg.sv */
`default_nettype none

package wrcd_pkg;

    localparam int unsigned C_WINDOW = 10;
    localparam logic [31:0] C_RESET_FILL = 32'd1048576000;
    localparam logic [31:0] C_THRESHOLD_RESET = 32'd1049;

    typedef struct packed {
        logic [31:0] var_x;
        logic [31:0] var_y;
        logic [31:0] var_z;
    } t_in;

    typedef struct packed {
        logic        converged;
        logic [31:0] range_x;
        logic [31:0] range_y;
        logic [31:0] range_z;
    } t_out;

    typedef struct packed {
        logic load;
        logic scan;
        logic first;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* sv/window_range_convergence_detector.sv */
`default_nettype none
// Sliding-window range convergence detector.
// Input channel (i_in_valid / o_in_ready, payload i_in): one transfer carries
// x, y and z variance samples in unsigned Q12.20. Each sample replaces the
// oldest entry of its own WINDOW-deep window.
// Output channel (o_out_valid / i_out_ready, payload o_out): one transfer per
// input, carrying max - min of each window and a converged flag that is set
// when all three ranges are strictly below the threshold register.
// Configuration: i_cfg_we writes i_cfg_wdata into the threshold at once.
// Timing: three lanes work side by side. After a transfer in, each lane
// rotates its window once through a min/max comparator, one entry per
// cycle, and the output register is then loaded from the three ranges.
// A new input is taken only after the previous result has moved into
// the output register.
// Stall: the output register holds its result until taken. The next item
// may be accepted and scanned meanwhile; it then waits in the lanes until
// the output register frees up.
// Reset (i_rst_n low, synchronous): all window entries go to 1000.0, the
// threshold to 1049 (about 0.001), and both channels go empty.

module window_range_convergence_detector #(
    parameter int unsigned WINDOW = wrcd_pkg::C_WINDOW
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire wrcd_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output wrcd_pkg::t_out      o_out,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_wdata
);
    import wrcd_pkg::*;

    localparam int unsigned CW = $clog2(WINDOW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [31:0]   r_threshold;
    logic          w_accept;
    logic          w_out_load;
    t_lane_ctl     w_ctl;
    logic [31:0]   w_range_x;
    logic [31:0]   w_range_y;
    logic [31:0]   w_range_z;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // Move the result into the output register once it is empty or draining.
    assign w_out_load = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    assign w_ctl.load  = w_accept;
    assign w_ctl.scan  = (r_state == S_SCAN);
    assign w_ctl.first = (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(WINDOW - 1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Threshold register; written directly, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= C_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // One lane per axis.
    wrcd_lane #(.WINDOW(WINDOW)) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.var_x),
        .o_range  (w_range_x)
    );

    wrcd_lane #(.WINDOW(WINDOW)) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.var_y),
        .o_range  (w_range_y)
    );

    wrcd_lane #(.WINDOW(WINDOW)) u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.var_z),
        .o_range  (w_range_z)
    );

    // Combine the lane ranges against the threshold and hold the result.
    wrcd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_out_load),
        .i_threshold (r_threshold),
        .i_range_x   (w_range_x),
        .i_range_y   (w_range_y),
        .i_range_z   (w_range_z),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* sv/wrcd_lane.sv */
`default_nettype none

module wrcd_lane #(
    parameter int unsigned WINDOW = wrcd_pkg::C_WINDOW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wrcd_pkg::t_lane_ctl i_ctl,
    input  wire logic [31:0]        i_sample,
    output logic [31:0]             o_range
);
    import wrcd_pkg::*;

    logic [31:0] r_win [WINDOW];
    logic [31:0] r_min;
    logic [31:0] r_max;
    logic [31:0] w_head;

    assign w_head = r_win[WINDOW-1];

    // Shift in on load; rotate once per scan cycle so the head visits every tap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= C_RESET_FILL;
            end
        end else if (i_ctl.load) begin
            r_win[0] <= i_sample;
            for (int k = 1; k < WINDOW; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end else if (i_ctl.scan) begin
            r_win[0] <= w_head;
            for (int k = 1; k < WINDOW; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            if (i_ctl.first || w_head < r_min) begin
                r_min <= w_head;
            end
            if (i_ctl.first || w_head > r_max) begin
                r_max <= w_head;
            end
        end
    end

    assign o_range = r_max - r_min;

endmodule

`default_nettype wire

/* sv/wrcd_merge.sv */
`default_nettype none

module wrcd_merge (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire logic [31:0]   i_threshold,
    input  wire logic [31:0]   i_range_x,
    input  wire logic [31:0]   i_range_y,
    input  wire logic [31:0]   i_range_z,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output wrcd_pkg::t_out     o_out
);
    import wrcd_pkg::*;

    logic r_valid;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.converged <= (i_range_x < i_threshold) && (i_range_y < i_threshold) &&
                               (i_range_z < i_threshold);
            r_out.range_x   <= i_range_x;
            r_out.range_y   <= i_range_y;
            r_out.range_z   <= i_range_z;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* sim/window_range_convergence_detector_tb.sv */
`default_nettype none

module window_range_convergence_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrcd_pkg::*;

    // Run limits, in clock cycles. The slowest correct run costs about
    // 1900 items times the scan plus the longest sender gap and receiver
    // stall, plus the long hold-off; the limit takes that several times over.
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLDOFF_LEN  = 300;
    localparam int HOLDOFF_AT   = 600;
    localparam int DRAIN_CYCLES = 4 * (C_WINDOW + 2);

    localparam logic [31:0] Q_FIVE  = 32'd5 << 20;
    localparam logic [31:0] Q_ALL1  = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_ZERO  = 32'd0;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_THRESHOLD} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in         samples;
        logic [31:0] limit;
        bit          typed;
        t_out        want;
    } t_stim_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    t_in         i_in         = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    t_out        o_out;
    logic        i_cfg_we     = 1'b0;
    logic [31:0] i_cfg_wdata  = '0;

    window_range_convergence_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Own copy of the block state: three sample windows, the write slot and
    // the threshold register.
    logic [31:0] lane_win [3][C_WINDOW];
    int unsigned next_slot;
    logic [31:0] threshold;

    // Expected results, oldest first, one per accepted input transfer.
    t_out        pending_ranges[$];
    t_stim_row   script[$];

    int          cycle_count      = 0;
    int          mismatches       = 0;
    int          items_sent       = 0;
    int          results_seen     = 0;
    int          converged_seen   = 0;
    int          thresholds_set   = 0;
    bit          calm             = 1'b0;
    bit          holdoff_done     = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_windows();
        int a;
        int k;
        for (a = 0; a < 3; a++) begin
            for (k = 0; k < C_WINDOW; k++) begin
                lane_win[a][k] = C_RESET_FILL;
            end
        end
        next_slot = 0;
        threshold = C_THRESHOLD_RESET;
    endfunction

    // Store one sample set in the current slot, scan each window for its
    // min and max, then advance the slot with wrap.
    function automatic t_out step_windows(t_in s);
        logic [31:0] smp [3];
        logic [31:0] span [3];
        logic [31:0] lo;
        logic [31:0] hi;
        int          a;
        int          k;
        t_out        r;
        smp[0] = s.var_x;
        smp[1] = s.var_y;
        smp[2] = s.var_z;
        for (a = 0; a < 3; a++) begin
            lane_win[a][next_slot] = smp[a];
            lo = lane_win[a][0];
            hi = lane_win[a][0];
            for (k = 1; k < C_WINDOW; k++) begin
                if (lane_win[a][k] < lo) lo = lane_win[a][k];
                if (lane_win[a][k] > hi) hi = lane_win[a][k];
            end
            span[a] = hi - lo;
        end
        next_slot = (next_slot + 1 >= C_WINDOW) ? 0 : next_slot + 1;
        r.converged = (span[0] < threshold) && (span[1] < threshold) &&
                      (span[2] < threshold);
        r.range_x = span[0];
        r.range_y = span[1];
        r.range_z = span[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic t_in pack3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in s;
        s.var_x = x;
        s.var_y = y;
        s.var_z = z;
        return s;
    endfunction

    function automatic void add_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_stim_row r;
        r.kind    = ROW_SAMPLE;
        r.samples = pack3(x, y, z);
        r.limit   = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        script.push_back(r);
    endfunction

    function automatic void add_typed(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic conv, logic [31:0] rx, logic [31:0] ry,
                                      logic [31:0] rz);
        t_stim_row r;
        r.kind           = ROW_SAMPLE;
        r.samples        = pack3(x, y, z);
        r.limit          = '0;
        r.typed          = 1'b1;
        r.want.converged = conv;
        r.want.range_x   = rx;
        r.want.range_y   = ry;
        r.want.range_z   = rz;
        script.push_back(r);
    endfunction

    function automatic void add_threshold(logic [31:0] v);
        t_stim_row r;
        r.kind    = ROW_THRESHOLD;
        r.samples = '0;
        r.limit   = v;
        r.typed   = 1'b0;
        r.want    = '0;
        script.push_back(r);
    endfunction

    function automatic void build_script();
        int k;
        // Right after reset every window holds 1000.0, so the ranges are
        // zero and the default threshold is met.
        add_typed(C_RESET_FILL, C_RESET_FILL, C_RESET_FILL, 1'b1, Q_ZERO, Q_ZERO, Q_ZERO);
        // Minimum and maximum samples against the 1000.0 fill.
        add_typed(Q_ZERO, C_RESET_FILL, C_RESET_FILL, 1'b0, C_RESET_FILL, Q_ZERO, Q_ZERO);
        add_typed(Q_ALL1, C_RESET_FILL, C_RESET_FILL, 1'b0, Q_ALL1, Q_ZERO, Q_ZERO);
        add_sample(C_RESET_FILL, Q_ZERO, Q_ALL1);
        // Settle all three windows around 5.0: a full window of tight
        // samples flushes the extremes and reaches convergence, with y one
        // step under the default threshold.
        for (k = 0; k < C_WINDOW; k++) begin
            add_sample(Q_FIVE + k * 100, (k % 2) ? Q_FIVE + 1048 : Q_FIVE, Q_FIVE);
        end
        // Range exactly at the threshold is not below it.
        add_sample(Q_FIVE - 149, Q_FIVE, Q_FIVE);
        // Zero threshold: nothing can converge.
        add_threshold(Q_ZERO);
        add_sample(Q_FIVE, Q_FIVE, Q_FIVE);
        // Full-scale threshold: converged unless a window spans full scale.
        add_threshold(Q_ALL1);
        add_sample(Q_FIVE, Q_FIVE, Q_FIVE);
        add_sample(Q_ZERO, Q_ZERO, Q_FIVE);
        add_sample(Q_ALL1, Q_FIVE, Q_ALL1);
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 1 << 20);
            1:       return C_RESET_FILL;
            2:       return Q_ALL1 - $urandom_range(0, 1 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return Q_ZERO;
            1:       return Q_ALL1;
            2:       return C_RESET_FILL;
            default: return $urandom;
        endcase
    endfunction

    // Spread of a settling run, chosen around the threshold so that runs
    // land just inside, on and just outside the limit.
    function automatic logic [31:0] pick_spread(logic [31:0] limit);
        logic [32:0] wide;
        case ($urandom_range(0, 4))
            0: return Q_ZERO;
            1: return (limit == 0) ? Q_ZERO : limit - 1;
            2: return limit;
            3: begin
                wide = {1'b0, limit} + $urandom_range(0, 1000);
                return wide[32] ? Q_ALL1 : wide[31:0];
            end
            default: return $urandom_range(0, limit);
        endcase
    endfunction

    function automatic logic [31:0] jitter(logic [31:0] base, logic [31:0] spread);
        logic [32:0] wide;
        wide = {1'b0, base} + $urandom_range(0, spread);
        return wide[32] ? Q_ALL1 : wide[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one sample set and hold it until the transfer; queue the
    // expected result at the accepting edge. A typed row queues its
    // hand-written result, but the predictor still advances.
    task automatic send_item(t_in s, bit typed, t_out want);
        int   gap;
        t_out predicted;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_windows(s);
        pending_ranges.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then write the register.
    task automatic set_threshold(logic [31:0] v);
        i_in_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        threshold = v;
        thresholds_set++;
    endtask

    // One phase at a fixed threshold: mostly settling runs of random
    // length around a random level, the rest scattered noise.
    task automatic run_phase(logic [31:0] limit, int n_items, bit quiet);
        logic [31:0] base [3];
        logic [31:0] spread [3];
        t_in         s;
        int          sent;
        int          len;
        int          k;
        int          a;
        set_threshold(limit);
        calm = quiet;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(C_WINDOW, 3 * C_WINDOW);
                for (a = 0; a < 3; a++) begin
                    base[a]   = pick_base();
                    spread[a] = pick_spread(limit);
                end
                for (k = 0; k < len; k++) begin
                    s.var_x = jitter(base[0], spread[0]);
                    s.var_y = jitter(base[1], spread[1]);
                    s.var_z = jitter(base[2], spread[2]);
                    send_item(s, 1'b0, '0);
                end
            end else begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    send_item(pack3(pick_noise(), pick_noise(), pick_noise()), 1'b0, '0);
                end
            end
            sent += len;
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off so the block
    // backs up and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------

    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge i_clk);
                holdoff_done = 1'b1;
            end
            n = gap_len();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat (calm ? 16 : $urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each output transfer with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out.converged === 1'b1) converged_seen++;
            if (pending_ranges.size() == 0) begin
                $error("result transfer with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_ranges.pop_front();
                check_field("converged", {31'b0, want.converged}, {31'b0, o_out.converged});
                check_field("range_x", want.range_x, o_out.range_x);
                check_field("range_y", want.range_y, o_out.range_y);
                check_field("range_z", want.range_z, o_out.range_z);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("window_range_convergence_detector verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        clear_windows();
        build_script();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (script[i]) begin
            if (script[i].kind == ROW_THRESHOLD) begin
                set_threshold(script[i].limit);
            end else begin
                send_item(script[i].samples, script[i].typed, script[i].want);
            end
        end

        // Random phases across the threshold range, one of them free of random
        // gaps on both sides.
        run_phase(Q_ALL1, 300, 1'b0);
        run_phase(Q_ZERO, 250, 1'b0);
        run_phase($urandom_range(1, 1 << 16), 350, 1'b1);
        run_phase($urandom_range(1 << 16, 1 << 28), 350, 1'b0);
        run_phase($urandom, 300, 1'b0);
        run_phase(C_THRESHOLD_RESET, 330, 1'b0);

        // Drain, then allow time for any stray result.
        i_in_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_ranges.size() != 0) begin
            $error("%0d expected results never arrived", pending_ranges.size());
            mismatches++;
        end

        $display("Sent %0d sample sets under %0d threshold settings; checked %0d results,",
                 items_sent, thresholds_set, results_seen);
        $display("%0d of them converged; %0d mismatches.", converged_seen, mismatches);
        if (mismatches == 0) begin
            $display("window_range_convergence_detector verification clean");
        end else begin
            $display("window_range_convergence_detector verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* window_range_convergence_detector.f */
sv/wrcd_pkg.sv
sv/wrcd_lane.sv
sv/wrcd_merge.sv
sv/window_range_convergence_detector.sv
sim/window_range_convergence_detector_tb.sv
